>>> sv/head_pose_window_smoother_core_macros.svh
// Assertion macros for the head pose smoother RTL.
`ifndef HEAD_POSE_WINDOW_SMOOTHER_CORE_MACROS_SVH
`define HEAD_POSE_WINDOW_SMOOTHER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPWS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("Head pose smoother assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define HPWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("Head pose smoother assertion failed.");

`endif

>>> sv/hpws_pkg.sv
// Shared types, constants and functions of the head pose smoother.
package hpws_pkg;

	localparam int HIST_DEPTH = 8;
	localparam int HIST_IW    = $clog2(HIST_DEPTH);
	localparam int LEN_W      = 4;
	localparam int AXES       = 6;
	localparam int DELTAS     = 3;
	localparam int TAG_W      = 16;
	localparam int POSE_W     = 15;
	localparam int DELTA_W    = 16;
	localparam int REL_W      = 16;
	localparam int STALE_W    = 5;
	localparam int STALE_MAX  = 31;
	localparam int Q15_ONE    = 32767;
	localparam int Q_SH       = 15;
	localparam int POSE_SH    = 14;
	localparam int DELTA_SH   = 8;

	localparam int SUM_W   = POSE_W + $clog2(HIST_DEPTH + 1);
	localparam int MAG_W   = SUM_W - 1;
	localparam int CNT_W   = $clog2(HIST_DEPTH + 2);
	localparam int DVD_W   = MAG_W + Q_SH;
	localparam int DVS_W   = CNT_W + POSE_SH;
	localparam int QB      = 17;
	localparam int DSH_W   = DVS_W + QB - 1;
	localparam int DIV_CW  = $clog2(QB);

	localparam int IN_DATA_W   = 160;
	localparam int IN_USER_W   = 3;
	localparam int OUT_DATA_W  = 152;
	localparam int OUT_USER_W  = 2;
	localparam int AXIS_LSB    = TAG_W;
	localparam int DELTA_LSB   = TAG_W + AXES * POSE_W;

	typedef logic [1:0] action_t;
	localparam action_t ACT_FRAME = 2'd0;
	localparam action_t ACT_START = 2'd1;
	localparam action_t ACT_STOP  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WALK,
		ST_DSTART,
		ST_DIV,
		ST_PUSH
	} hpws_state_t;

	typedef struct packed {
		logic load;
		logic walk_init;
		logic walk_step;
		logic div_start;
		logic div_step;
		logic commit;
	} hpws_cmd_t;

	typedef struct packed {
		logic new_frame;
		logic len_zero;
		logic walk_last;
		logic out_free;
	} hpws_sts_t;

	function automatic logic signed [REL_W-1:0] delta_to_q15(logic signed [DELTA_W-1:0] d);
		logic [DELTA_W-1:0]       mag;
		logic [DELTA_W+Q_SH-1:0]  prod;
		logic [DELTA_W+Q_SH-DELTA_SH-1:0] sh;
		logic [Q_SH-1:0]          lim;
		logic signed [REL_W-1:0]  r;
		mag  = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
		prod = ((DELTA_W+Q_SH)'(mag) << Q_SH) - (DELTA_W+Q_SH)'(mag);
		sh   = prod[DELTA_W+Q_SH-1:DELTA_SH];
		lim  = (sh > (DELTA_W+Q_SH-DELTA_SH)'(Q15_ONE)) ? Q_SH'(Q15_ONE) : sh[Q_SH-1:0];
		r    = {1'b0, lim};
		return d[DELTA_W-1] ? -r : r;
	endfunction

endpackage

>>> sv/hpws_div.sv
// Bit-serial restoring divider lane that scales one axis sum to Q1.15.
module hpws_div (
	input  logic                                   clk,
	input  logic                                   start,
	input  logic                                   step,
	input  logic signed [hpws_pkg::SUM_W-1:0]      sum,
	input  logic [hpws_pkg::CNT_W-1:0]             count,
	output logic signed [hpws_pkg::REL_W-1:0]      quo
);

	logic                              neg_q;
	logic [hpws_pkg::DVD_W-1:0]        rem_q;
	logic [hpws_pkg::DSH_W-1:0]        dsh_q;
	logic [hpws_pkg::QB-1:0]           quo_q;
	logic [hpws_pkg::MAG_W-1:0]        mag;
	logic [hpws_pkg::DVS_W-1:0]        dvs;
	logic [hpws_pkg::Q_SH-1:0]         lim;
	logic signed [hpws_pkg::REL_W-1:0] pos;

	always_comb begin
		mag = sum[hpws_pkg::SUM_W-1] ? hpws_pkg::MAG_W'(-sum) : hpws_pkg::MAG_W'(sum);
		dvs = (hpws_pkg::DVS_W'(count) << hpws_pkg::POSE_SH) - hpws_pkg::DVS_W'(count);
		lim = (quo_q > hpws_pkg::QB'(hpws_pkg::Q15_ONE)) ?
			hpws_pkg::Q_SH'(hpws_pkg::Q15_ONE) : quo_q[hpws_pkg::Q_SH-1:0];
		pos = {1'b0, lim};
		quo = neg_q ? -pos : pos;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= sum[hpws_pkg::SUM_W-1];
			rem_q <= (hpws_pkg::DVD_W'(mag) << hpws_pkg::Q_SH) - hpws_pkg::DVD_W'(mag);
			dsh_q <= hpws_pkg::DSH_W'(dvs) << (hpws_pkg::QB - 1);
			quo_q <= '0;
		end else if (step) begin
			if ({1'b0, rem_q} >= dsh_q) begin
				rem_q <= rem_q - dsh_q[hpws_pkg::DVD_W-1:0];
				quo_q <= {quo_q[hpws_pkg::QB-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[hpws_pkg::QB-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

>>> sv/hpws_ctrl.sv
// Controller state machine sequencing accept, history walk, division and result.
module hpws_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hpws_pkg::hpws_sts_t  sts,
	output hpws_pkg::hpws_cmd_t  cmd
);

	hpws_pkg::hpws_state_t        state_q, state_nx;
	logic [hpws_pkg::DIV_CW-1:0]  cnt_q;
	logic                         div_last;

	assign div_last = (cnt_q == hpws_pkg::DIV_CW'(hpws_pkg::QB - 1));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			hpws_pkg::ST_IDLE: begin
				if (in_valid) state_nx = hpws_pkg::ST_EVAL;
			end
			hpws_pkg::ST_EVAL: begin
				if (!sts.new_frame) state_nx = hpws_pkg::ST_PUSH;
				else if (sts.len_zero) state_nx = hpws_pkg::ST_DSTART;
				else state_nx = hpws_pkg::ST_WALK;
			end
			hpws_pkg::ST_WALK: begin
				if (sts.walk_last) state_nx = hpws_pkg::ST_DSTART;
			end
			hpws_pkg::ST_DSTART: state_nx = hpws_pkg::ST_DIV;
			hpws_pkg::ST_DIV: begin
				if (div_last) state_nx = hpws_pkg::ST_PUSH;
			end
			hpws_pkg::ST_PUSH: begin
				if (sts.out_free) state_nx = hpws_pkg::ST_IDLE;
			end
			default: state_nx = hpws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			hpws_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			hpws_pkg::ST_EVAL:   cmd.walk_init = sts.new_frame;
			hpws_pkg::ST_WALK:   cmd.walk_step = 1'b1;
			hpws_pkg::ST_DSTART: cmd.div_start = 1'b1;
			hpws_pkg::ST_DIV:    cmd.div_step = 1'b1;
			hpws_pkg::ST_PUSH:   cmd.commit = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpws_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_start) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

>>> sv/hpws_dp.sv
// Datapath: item register, history ring, axis sums, divider lanes and held results.
module hpws_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hpws_pkg::hpws_cmd_t                  cmd,
	output hpws_pkg::hpws_sts_t                  sts,
	input  logic                                 cfg_we,
	input  logic [hpws_pkg::LEN_W-1:0]           cfg_wdata,
	input  logic [hpws_pkg::IN_DATA_W-1:0]       in_data,
	input  logic [hpws_pkg::IN_USER_W-1:0]       in_user,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [hpws_pkg::OUT_DATA_W-1:0]      out_data,
	output logic [hpws_pkg::OUT_USER_W-1:0]      out_user
);

	logic [hpws_pkg::IN_DATA_W-1:0]    data_q;
	logic [hpws_pkg::IN_USER_W-1:0]    user_q;
	logic [hpws_pkg::LEN_W-1:0]        hl_q;
	logic                              running_q;
	logic                              status_q;
	logic [hpws_pkg::TAG_W-1:0]        last_tag_q;
	logic [hpws_pkg::STALE_W-1:0]      stale_q;
	logic [hpws_pkg::HIST_IW-1:0]      head_q;
	logic [hpws_pkg::HIST_DEPTH-1:0]   valid_q;
	logic signed [hpws_pkg::POSE_W-1:0] hist_q [hpws_pkg::HIST_DEPTH][hpws_pkg::AXES];
	logic signed [hpws_pkg::SUM_W-1:0] sum_q [hpws_pkg::AXES];
	logic [hpws_pkg::CNT_W-1:0]        cnt_q;
	logic [hpws_pkg::HIST_IW-1:0]      idx_q;
	logic signed [hpws_pkg::REL_W-1:0] held_q [hpws_pkg::AXES + hpws_pkg::DELTAS];
	logic                              upd_q;
	logic                              out_valid_q;

	hpws_pkg::action_t                 action;
	logic                              status_in;
	logic [hpws_pkg::TAG_W-1:0]        tag;
	logic signed [hpws_pkg::POSE_W-1:0] axis [hpws_pkg::AXES];
	logic signed [hpws_pkg::DELTA_W-1:0] delta [hpws_pkg::DELTAS];
	logic signed [hpws_pkg::REL_W-1:0] rel_axis [hpws_pkg::AXES];
	logic [hpws_pkg::LEN_W-1:0]        len_eff;
	logic [hpws_pkg::HIST_IW-1:0]      head_adj;
	logic [hpws_pkg::HIST_IW-1:0]      head_nx;

	always_comb begin
		action    = user_q[1:0];
		status_in = user_q[2];
		tag       = data_q[hpws_pkg::TAG_W-1:0];
		for (int k = 0; k < hpws_pkg::AXES; k++)
			axis[k] = data_q[hpws_pkg::AXIS_LSB + k*hpws_pkg::POSE_W +: hpws_pkg::POSE_W];
		for (int k = 0; k < hpws_pkg::DELTAS; k++)
			delta[k] = data_q[hpws_pkg::DELTA_LSB + k*hpws_pkg::DELTA_W +: hpws_pkg::DELTA_W];
		len_eff = (hl_q > hpws_pkg::LEN_W'(hpws_pkg::HIST_DEPTH)) ?
			hpws_pkg::LEN_W'(hpws_pkg::HIST_DEPTH) : hl_q;
		head_adj = (hpws_pkg::LEN_W'(head_q) >= len_eff) ? '0 : head_q;
		head_nx  = (hpws_pkg::LEN_W'(head_adj) + 1'b1 == len_eff) ? '0 : head_adj + 1'b1;
		sts.new_frame = (action == hpws_pkg::ACT_FRAME) && running_q && status_in &&
			(tag != last_tag_q);
		sts.len_zero  = (len_eff == '0);
		sts.walk_last = (hpws_pkg::LEN_W'(idx_q) == len_eff - 1'b1);
		sts.out_free  = !out_valid_q || out_ready;
	end

	for (genvar g = 0; g < hpws_pkg::AXES; g++) begin : g_lane
		hpws_div u_div (
			.clk   (clk),
			.start (cmd.div_start),
			.step  (cmd.div_step),
			.sum   (sum_q[g]),
			.count (cnt_q),
			.quo   (rel_axis[g])
		);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= in_data;
			user_q <= in_user;
		end
		if (cmd.walk_init) begin
			for (int k = 0; k < hpws_pkg::AXES; k++) sum_q[k] <= hpws_pkg::SUM_W'(axis[k]);
			cnt_q <= hpws_pkg::CNT_W'(1);
			idx_q <= '0;
		end else if (cmd.walk_step) begin
			if (valid_q[idx_q]) begin
				for (int k = 0; k < hpws_pkg::AXES; k++)
					sum_q[k] <= sum_q[k] + hpws_pkg::SUM_W'(hist_q[idx_q][k]);
				cnt_q <= cnt_q + 1'b1;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.commit && sts.new_frame && !sts.len_zero) begin
			for (int k = 0; k < hpws_pkg::AXES; k++) hist_q[head_adj][k] <= axis[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q        <= '0;
			running_q   <= 1'b0;
			status_q    <= 1'b0;
			last_tag_q  <= '0;
			stale_q     <= '0;
			head_q      <= '0;
			valid_q     <= '0;
			upd_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < hpws_pkg::AXES + hpws_pkg::DELTAS; k++) held_q[k] <= '0;
		end else begin
			if (cfg_we) begin
				hl_q    <= cfg_wdata;
				valid_q <= '0;
				head_q  <= '0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				upd_q       <= 1'b0;
				case (action)
					hpws_pkg::ACT_FRAME: begin
						if (running_q) begin
							status_q <= status_in;
							if (status_in && tag == last_tag_q) begin
								if (stale_q != hpws_pkg::STALE_W'(hpws_pkg::STALE_MAX))
									stale_q <= stale_q + 1'b1;
							end else if (status_in) begin
								last_tag_q <= tag;
								stale_q    <= '0;
								upd_q      <= 1'b1;
								for (int k = 0; k < hpws_pkg::AXES; k++)
									held_q[k] <= rel_axis[k];
								for (int k = 0; k < hpws_pkg::DELTAS; k++)
									held_q[hpws_pkg::AXES + k] <= hpws_pkg::delta_to_q15(delta[k]);
								if (!sts.len_zero) begin
									valid_q[head_adj] <= 1'b1;
									head_q <= head_nx;
								end
							end
						end
					end
					hpws_pkg::ACT_START: begin
						if (!running_q) begin
							running_q  <= 1'b1;
							last_tag_q <= '0;
							stale_q    <= '0;
						end
					end
					hpws_pkg::ACT_STOP: running_q <= 1'b0;
					default: ;
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_data = '0;
		for (int k = 0; k < hpws_pkg::AXES + hpws_pkg::DELTAS; k++)
			out_data[k*hpws_pkg::REL_W +: hpws_pkg::REL_W] = held_q[k];
		out_data[(hpws_pkg::AXES + hpws_pkg::DELTAS)*hpws_pkg::REL_W +: hpws_pkg::STALE_W] = stale_q;
		out_user  = {running_q && status_q, upd_q};
		out_valid = out_valid_q;
	end

endmodule

>>> sv/head_pose_window_smoother_core.sv
// Top level of the head pose smoother: a new frame goes IDLE, EVAL, WALK, DSTART, DIV, PUSH.
// Any other item (repeated tag, start, stop, inactive frame) goes IDLE, EVAL, PUSH, IDLE.
// WALK visits history_len ring slots (at most 8; skipped at 0), then DIV runs 17 divider steps.
// Reset is asynchronous and clears control, ring valid bits and held results to zero.
`include "head_pose_window_smoother_core_macros.svh"
module head_pose_window_smoother_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hpws_pkg::LEN_W-1:0]          cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// frame_tag, yaw_in, pitch_in, roll_in, pos_x_in, pos_y_in, pos_z_in,
	// delta_x_in, delta_y_in, delta_z_in, then zero fill.
	input  logic [hpws_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// action, status_active.
	input  logic [hpws_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// rel_yaw, rel_pitch, rel_roll, rel_x, rel_y, rel_z, rel_delta_x,
	// rel_delta_y, rel_delta_z, stale_count, then zero fill.
	output logic [hpws_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// updated, tracking_active.
	output logic [hpws_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

	hpws_pkg::hpws_cmd_t cmd;
	hpws_pkg::hpws_sts_t sts;

	hpws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hpws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	`HPWS_ASSERT_HOLDS(a_commit_slot_free, clk, arst_n, cmd.commit, !m_axis_tvalid || m_axis_tready)
	`HPWS_ASSERT_HOLDS(a_update_clears_stale, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[148:144] == 5'd0)
	`HPWS_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

>>> tb/tb_head_pose_window_smoother_core.sv
// Self-checking testbench for the head pose window smoother core.
`timescale 1ns / 1ps
module tb_head_pose_window_smoother_core;

	localparam hpws_pkg::action_t ACT_UNUSED = 2'd3;

	typedef struct {
		logic        updated;
		logic        tracking;
		logic [15:0] rel [0:8];
		logic [4:0]  stale;
	} pose_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [hpws_pkg::LEN_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [hpws_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [hpws_pkg::IN_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [hpws_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [hpws_pkg::OUT_USER_W-1:0] m_axis_tuser;

	head_pose_window_smoother_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow state of the smoother.
	int unsigned win_len;
	bit is_running, last_status;
	logic [15:0] prev_tag;
	int unsigned stale_cnt, head_slot;
	bit slot_valid [0:7];
	int slot_axis [0:7][0:5];
	logic [15:0] held_rel [0:8];

	pose_result_t pending_results[$];
	int mismatches = 0;
	int burst_left = 0;

	function automatic int clamp_q(longint v);
		if (v > hpws_pkg::Q15_ONE) return hpws_pkg::Q15_ONE;
		if (v < -hpws_pkg::Q15_ONE) return -hpws_pkg::Q15_ONE;
		return int'(v);
	endfunction

	function automatic void predict_smoothed(logic [1:0] act, logic st,
			logic [hpws_pkg::IN_DATA_W-1:0] d);
		pose_result_t r;
		logic [15:0] tag;
		int a [0:5];
		int dl [0:2];
		longint sums [0:5];
		longint cnt;
		int unsigned len;
		r.updated = 1'b0;
		tag = d[15:0];
		len = (win_len > hpws_pkg::HIST_DEPTH) ? hpws_pkg::HIST_DEPTH : win_len;
		if (act == hpws_pkg::ACT_FRAME && is_running) begin
			last_status = st;
			if (st) begin
				if (tag == prev_tag) begin
					if (stale_cnt < hpws_pkg::STALE_MAX) stale_cnt++;
				end else begin
					cnt = 1;
					for (int k = 0; k < 6; k++) begin
						a[k] = int'($signed(d[hpws_pkg::AXIS_LSB + k*hpws_pkg::POSE_W
							+: hpws_pkg::POSE_W]));
						sums[k] = a[k];
					end
					for (int k = 0; k < 3; k++)
						dl[k] = int'($signed(d[hpws_pkg::DELTA_LSB + k*hpws_pkg::DELTA_W
							+: hpws_pkg::DELTA_W]));
					if (len > 0) begin
						for (int i = 0; i < len; i++) begin
							if (slot_valid[i]) begin
								for (int k = 0; k < 6; k++) sums[k] += slot_axis[i][k];
								cnt++;
							end
						end
						if (head_slot >= len) head_slot = 0;
						for (int k = 0; k < 6; k++) slot_axis[head_slot][k] = a[k];
						slot_valid[head_slot] = 1'b1;
						head_slot = (head_slot + 1) % len;
					end
					for (int k = 0; k < 6; k++)
						held_rel[k] = 16'(clamp_q((sums[k] * hpws_pkg::Q15_ONE) / (cnt * 16383)));
					for (int k = 0; k < 3; k++)
						held_rel[6+k] = 16'(clamp_q((longint'(dl[k]) * hpws_pkg::Q15_ONE) / 256));
					prev_tag = tag;
					stale_cnt = 0;
					r.updated = 1'b1;
				end
			end
		end else if (act == hpws_pkg::ACT_START) begin
			if (!is_running) begin
				is_running = 1'b1;
				prev_tag = '0;
				stale_cnt = 0;
			end
		end else if (act == hpws_pkg::ACT_STOP) begin
			is_running = 1'b0;
		end
		r.tracking = is_running && last_status;
		r.rel = held_rel;
		r.stale = 5'(stale_cnt);
		pending_results.push_back(r);
	endfunction

	task automatic send_item(logic [1:0] act, logic st, logic [hpws_pkg::IN_DATA_W-1:0] d);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= {st, act};
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		predict_smoothed(act, st, d);
	endtask

	function automatic logic [hpws_pkg::IN_DATA_W-1:0] pack_frame(logic [15:0] tag,
			logic [14:0] p0, logic [14:0] p1, logic [14:0] p2, logic [14:0] p3,
			logic [14:0] p4, logic [14:0] p5, logic [15:0] d0, logic [15:0] d1,
			logic [15:0] d2);
		logic [hpws_pkg::IN_DATA_W-1:0] v;
		v = '0;
		v[15:0] = tag;
		v[hpws_pkg::AXIS_LSB +: 90] = {p5, p4, p3, p2, p1, p0};
		v[hpws_pkg::DELTA_LSB +: 48] = {d2, d1, d0};
		return v;
	endfunction

	function automatic logic [hpws_pkg::IN_DATA_W-1:0] rand_frame(logic [15:0] tag);
		logic [hpws_pkg::IN_DATA_W-1:0] v;
		v = '0;
		for (int i = 0; i < 5; i++) v[i*32 +: 32] = $urandom;
		v[hpws_pkg::IN_DATA_W-1 -: 6] = '0;
		v[15:0] = tag;
		return v;
	endfunction

	task automatic drain_and_set_len(int unsigned len);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= hpws_pkg::LEN_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		win_len = len;
		head_slot = 0;
		for (int i = 0; i < 8; i++) slot_valid[i] = 1'b0;
	endtask

	task automatic test_directed();
		send_item(hpws_pkg::ACT_FRAME, 1'b1, pack_frame(16'd5, 15'h3fff, '0, '0, '0, '0, '0,
			'0, '0, '0));
		send_item(hpws_pkg::ACT_STOP, 1'b0, '0);
		send_item(hpws_pkg::ACT_START, 1'b0, '0);
		send_item(hpws_pkg::ACT_START, 1'b1, '0);
		send_item(hpws_pkg::ACT_FRAME, 1'b1, pack_frame(16'd0, '0, '0, '0, '0, '0, '0,
			'0, '0, '0));
		send_item(hpws_pkg::ACT_FRAME, 1'b1, pack_frame(16'hffff, 15'h3fff, 15'h4000,
			15'h3fff, 15'h4000, 15'h7fff, 15'h0001, 16'h7fff, 16'h8000, 16'h0100));
		send_item(hpws_pkg::ACT_FRAME, 1'b1, pack_frame(16'hffff, '0, '0, '0, '0, '0, '0,
			'0, '0, '0));
		send_item(hpws_pkg::ACT_FRAME, 1'b0, pack_frame(16'h1234, 15'd1, 15'd1, 15'd1,
			15'd1, 15'd1, 15'd1, 16'd1, 16'd1, 16'd1));
		send_item(hpws_pkg::ACT_FRAME, 1'b1, pack_frame(16'h1234, 15'h4000, 15'h4000,
			15'h4000, 15'h4000, 15'h4000, 15'h4000, 16'hff00, 16'h00ff, 16'hffff));
		send_item(ACT_UNUSED, 1'b1, rand_frame(16'h55aa));
		send_item(hpws_pkg::ACT_STOP, 1'b1, '0);
		send_item(hpws_pkg::ACT_STOP, 1'b1, '0);
		send_item(hpws_pkg::ACT_FRAME, 1'b1, rand_frame(16'h7777));
	endtask

	task automatic test_stale_saturation();
		send_item(hpws_pkg::ACT_START, 1'b0, '0);
		send_item(hpws_pkg::ACT_FRAME, 1'b1, rand_frame(16'h0042));
		repeat (35) send_item(hpws_pkg::ACT_FRAME, 1'b1, rand_frame(16'h0042));
		send_item(hpws_pkg::ACT_STOP, 1'b0, '0);
	endtask

	task automatic test_random(int unsigned n);
		logic [15:0] tag;
		int r;
		tag = 16'($urandom);
		send_item(hpws_pkg::ACT_START, 1'b0, '0);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				tag = tag + 16'($urandom_range(1, 3));
				send_item(hpws_pkg::ACT_FRAME, 1'b1, rand_frame(tag));
			end else if (r < 80) send_item(hpws_pkg::ACT_FRAME, 1'b1, rand_frame(tag));
			else if (r < 87) send_item(hpws_pkg::ACT_FRAME, 1'b0, rand_frame(16'($urandom)));
			else if (r < 91)
				send_item(hpws_pkg::ACT_START, 1'($urandom), rand_frame(16'($urandom)));
			else if (r < 95)
				send_item(hpws_pkg::ACT_STOP, 1'($urandom), rand_frame(16'($urandom)));
			else if (r < 97) send_item(ACT_UNUSED, 1'($urandom), rand_frame(16'($urandom)));
			else send_item(hpws_pkg::ACT_FRAME, 1'b1, rand_frame(16'($urandom)));
		end
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			pose_result_t e;
			bit bad;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Result arrived with none expected.");
			end else begin
				e = pending_results.pop_front();
				bad = (m_axis_tuser[0] !== e.updated) || (m_axis_tuser[1] !== e.tracking)
					|| (m_axis_tdata[144 +: 5] !== e.stale);
				for (int k = 0; k < 9; k++)
					if (m_axis_tdata[k*16 +: 16] !== e.rel[k]) bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected upd %0b trk %0b stale %0d rel %p,",
							e.updated, e.tracking, e.stale, e.rel,
							" got tuser %b tdata %h", m_axis_tuser, m_axis_tdata);
				end
			end
		end
	end

	initial begin
		int phase;
		forever begin
			@(posedge clk);
			phase = $urandom_range(0, 3);
			if (phase == 0) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'($urandom_range(0, 2) != 0);
			end
		end
	end

	initial begin
		#50000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		win_len = 0;
		is_running = 0;
		last_status = 0;
		prev_tag = '0;
		stale_cnt = 0;
		head_slot = 0;
		for (int i = 0; i < 8; i++) slot_valid[i] = 1'b0;
		for (int i = 0; i < 9; i++) held_rel[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_and_set_len(8);
		test_directed();
		test_stale_saturation();
		test_random(250);
		drain_and_set_len(3);
		test_random(250);
		drain_and_set_len(15);
		test_random(200);
		drain_and_set_len(0);
		test_random(150);
		drain_and_set_len(1);
		test_random(150);
		drain_and_set_len(5);
		test_random(100);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> head_pose_window_smoother_core.f
+incdir+sv
sv/hpws_pkg.sv
sv/hpws_div.sv
sv/hpws_ctrl.sv
sv/hpws_dp.sv
sv/head_pose_window_smoother_core.sv
tb/tb_head_pose_window_smoother_core.sv
